// ===== rtl/jfrc_pkg.sv =====
package jfrc_pkg;

    localparam int unsigned MAX_RECORD_BYTES_DEF  = 65536;
    localparam int unsigned MAX_KIND_BYTES_DEF    = 4096;
    localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 65536;

    localparam logic [31:0] FRAME_MAGIC  = 32'h524A5243;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;
    localparam logic [31:0] HEADER_BYTES = 32'd8;

    typedef enum logic [3:0] {
        V_REPLAYED  = 4'd0,
        V_ZERO_EP   = 4'd1,
        V_STALE     = 4'd2,
        V_MAGIC     = 4'd3,
        V_LENGTH    = 4'd4,
        V_CHECKSUM  = 4'd5,
        V_MALFORMED = 4'd6,
        V_SEQUENCE  = 4'd7,
        V_TRUNCATED = 4'd8,
        V_CLEAN_END = 4'd9
    } verdict_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [63:0] record_sequence;
        logic [63:0] record_tick;
        logic [63:0] record_epoch;
        logic [31:0] frame_start;
        logic [12:0] kind_bytes;
        logic [16:0] payload_bytes;
        logic [31:0] replayed_total;
        logic [31:0] rejected_total;
        logic [31:0] truncated_total;
        logic        final_res;
    } out_item_t;

    // frame event from the parser to the accounting stage
    typedef struct packed {
        logic [3:0]  verdict;
        logic [63:0] record_sequence;
        logic [63:0] record_tick;
        logic [63:0] record_epoch;
        logic [31:0] frame_start;
        logic [12:0] kind_bytes;
        logic [16:0] payload_bytes;
        logic [31:0] trunc_bytes;
        logic        final_res;
    } event_t;

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] v);
        logic [31:0] c;
        c = crc ^ {24'd0, v};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] n);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, n};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

endpackage

// ===== rtl/jfrc_parser.sv =====
module jfrc_parser
    import jfrc_pkg::*;
#(
    parameter int unsigned MAX_RECORD_BYTES  = MAX_RECORD_BYTES_DEF,
    parameter int unsigned MAX_KIND_BYTES    = MAX_KIND_BYTES_DEF,
    parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] coord_epoch,
    input  logic        byte_valid,
    input  in_item_t    byte_in,
    output logic        ev_valid,
    output event_t      ev
);

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0, PH_SEQ = 4'd1, PH_TICK = 4'd2, PH_EPOCH = 4'd3,
        PH_KLEN = 4'd4, PH_KIND = 4'd5, PH_PLEN = 4'd6, PH_PAY = 4'd7,
        PH_DONE = 4'd8, PH_SKIP = 4'd9
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] blen_reg, blen_next;
    logic [31:0] crc_reg, crc_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] seq_reg, seq_next, tick_reg, tick_next, epoch_reg, epoch_next;
    logic [12:0] klen_reg, klen_next;
    logic [16:0] plen_reg, plen_next;
    logic        fmagic_reg, fmagic_next, flen_reg, flen_next, fbody_reg, fbody_next;
    logic [63:0] high_reg, high_next;
    logic [31:0] offs_reg, offs_next, base_reg, base_next;
    logic        halt_reg, halt_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [31:0] left_reg, left_next;

    logic        have_v;
    logic [3:0]  v;
    logic [7:0]  b;
    logic        last;
    logic [31:0] rel, tail;
    logic        term;
    logic [63:0] fs;
    logic [63:0] bshift;

    always_comb begin
        phase_next = phase_reg; count_next = count_reg; blen_next = blen_reg;
        crc_next = crc_reg; shift_next = shift_reg; seq_next = seq_reg;
        tick_next = tick_reg; epoch_next = epoch_reg; klen_next = klen_reg;
        plen_next = plen_reg; fmagic_next = fmagic_reg; flen_next = flen_reg;
        fbody_next = fbody_reg; high_next = high_reg; offs_next = offs_reg;
        base_next = base_reg; halt_next = halt_reg; fidx_next = fidx_reg;
        left_next = left_reg;
        b = byte_in.stream_byte;
        last = byte_in.end_of_stream;
        have_v = 1'b0;
        v = V_REPLAYED;
        rel = count_reg - HEADER_BYTES;
        tail = rel - blen_reg;
        fs = 64'd0;
        bshift = {56'd0, b} << {fidx_reg, 3'b000};
        term = 1'b0;
        ev = '0;
        ev_valid = 1'b0;
        if (byte_valid) begin
            if (halt_reg) begin
                if (last) begin
                    halt_next = 1'b0; phase_next = PH_HEADER; count_next = '0;
                    blen_next = '0; crc_next = ALL_ONES; shift_next = '0;
                    seq_next = '0; tick_next = '0; epoch_next = '0; klen_next = '0;
                    plen_next = '0; fmagic_next = 1'b0; flen_next = 1'b0;
                    fbody_next = 1'b0; fidx_next = '0; left_next = '0;
                    high_next = '0; offs_next = '0; base_next = '0;
                end
            end else begin
                if (count_reg < HEADER_BYTES) begin
                    crc_next = crc_byte(crc_reg, b);
                    fs = shift_reg | ({56'd0, b} << {count_reg[1:0], 3'b000});
                    shift_next = fs;
                    if (count_reg == 32'd3) begin
                        if (fs[31:0] != FRAME_MAGIC) fmagic_next = 1'b1;
                        shift_next = '0;
                    end else if (count_reg == 32'd7) begin
                        blen_next = fs[31:0];
                        flen_next = fs[31:0] > 32'(MAX_RECORD_BYTES);
                        shift_next = '0;
                        fidx_next = '0;
                        phase_next = (fmagic_reg || flen_next) ? PH_SKIP : PH_SEQ;
                    end
                end else if (phase_reg == PH_SKIP) begin
                    if (count_reg == HEADER_BYTES + 32'd3) begin
                        have_v = 1'b1;
                        v = fmagic_reg ? V_MAGIC : V_LENGTH;
                    end
                end else if (rel < blen_reg) begin
                    crc_next = crc_byte(crc_reg, b);
                    if (!fbody_reg) begin
                        unique case (phase_reg)
                            PH_SEQ, PH_TICK, PH_EPOCH, PH_KLEN, PH_PLEN: begin
                                fs = shift_reg | bshift;
                                shift_next = fs;
                                fidx_next = fidx_reg + 3'd1;
                                if ((phase_reg inside {PH_KLEN, PH_PLEN} && fidx_reg == 3'd3)
                                    || fidx_reg == 3'd7) begin
                                    fidx_next = '0;
                                    shift_next = '0;
                                    unique case (phase_reg)
                                        PH_SEQ: begin
                                            seq_next = fs; phase_next = PH_TICK;
                                        end
                                        PH_TICK: begin
                                            tick_next = fs; phase_next = PH_EPOCH;
                                        end
                                        PH_EPOCH: begin
                                            epoch_next = fs; phase_next = PH_KLEN;
                                        end
                                        PH_KLEN: begin
                                            if (fs > 64'(MAX_KIND_BYTES)) fbody_next = 1'b1;
                                            else begin
                                                klen_next = fs[12:0];
                                                left_next = fs[31:0];
                                                phase_next = (fs[31:0] != 0) ? PH_KIND : PH_PLEN;
                                            end
                                        end
                                        default: begin
                                            if (fs > 64'(MAX_PAYLOAD_BYTES)) fbody_next = 1'b1;
                                            else begin
                                                plen_next = fs[16:0];
                                                left_next = fs[31:0];
                                                phase_next = (fs[31:0] != 0) ? PH_PAY : PH_DONE;
                                            end
                                        end
                                    endcase
                                end
                            end
                            PH_KIND, PH_PAY: begin
                                left_next = left_reg - 32'd1;
                                if (left_reg == 32'd1)
                                    phase_next = (phase_reg == PH_KIND) ? PH_PLEN : PH_DONE;
                            end
                            default: fbody_next = 1'b1;
                        endcase
                    end
                end else begin
                    fs = (tail[1:0] == 2'd0) ? 64'd0 : shift_reg;
                    if (tail[1:0] == 2'd0 && phase_reg != PH_DONE) fbody_next = 1'b1;
                    fs = fs | ({56'd0, b} << {tail[1:0], 3'b000});
                    shift_next = fs;
                    if (tail[1:0] == 2'd3) begin
                        have_v = 1'b1;
                        if ((crc_reg ^ ALL_ONES) != fs[31:0]) v = V_CHECKSUM;
                        else if (fbody_reg) v = V_MALFORMED;
                        else if (epoch_reg == '0) v = V_ZERO_EP;
                        else if (seq_reg <= high_reg) v = V_SEQUENCE;
                        else begin
                            high_next = seq_reg;
                            v = (coord_epoch != '0 && epoch_reg < coord_epoch)
                                ? V_STALE : V_REPLAYED;
                        end
                    end
                end

                if (!have_v && !last) begin
                    count_next = count_reg + 32'd1;
                    offs_next = offs_reg + 32'd1;
                end else begin
                    if (!have_v) v = V_TRUNCATED;
                    term = (v >= V_MAGIC) && (v <= V_SEQUENCE);
                    ev_valid = 1'b1;
                    // fields completed by this very beat are reported too
                    ev.verdict = v;
                    ev.record_sequence = seq_next;
                    ev.record_tick = tick_next;
                    ev.record_epoch = epoch_next;
                    ev.frame_start = base_reg;
                    ev.kind_bytes = klen_next;
                    ev.payload_bytes = plen_next;
                    ev.trunc_bytes = count_reg + 32'd1;
                    ev.final_res = last || term;
                    if (term && !last) begin
                        halt_next = 1'b1;
                    end else begin
                        phase_next = PH_HEADER; count_next = '0; blen_next = '0;
                        crc_next = ALL_ONES; shift_next = '0; seq_next = '0;
                        tick_next = '0; epoch_next = '0; klen_next = '0;
                        plen_next = '0; fmagic_next = 1'b0; flen_next = 1'b0;
                        fbody_next = 1'b0; fidx_next = '0; left_next = '0;
                        if (last) begin
                            high_next = '0; offs_next = '0; base_next = '0;
                        end else begin
                            offs_next = offs_reg + 32'd1;
                            base_next = offs_reg + 32'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; count_reg <= '0; blen_reg <= '0;
            crc_reg <= ALL_ONES; shift_reg <= '0; seq_reg <= '0; tick_reg <= '0;
            epoch_reg <= '0; klen_reg <= '0; plen_reg <= '0; fmagic_reg <= 1'b0;
            flen_reg <= 1'b0; fbody_reg <= 1'b0; high_reg <= '0; offs_reg <= '0;
            base_reg <= '0; halt_reg <= 1'b0; fidx_reg <= '0; left_reg <= '0;
        end else begin
            phase_reg <= phase_next; count_reg <= count_next; blen_reg <= blen_next;
            crc_reg <= crc_next; shift_reg <= shift_next; seq_reg <= seq_next;
            tick_reg <= tick_next; epoch_reg <= epoch_next; klen_reg <= klen_next;
            plen_reg <= plen_next; fmagic_reg <= fmagic_next; flen_reg <= flen_next;
            fbody_reg <= fbody_next; high_reg <= high_next; offs_reg <= offs_next;
            base_reg <= base_next; halt_reg <= halt_next; fidx_reg <= fidx_next;
            left_reg <= left_next;
        end
    end

endmodule

// ===== rtl/jfrc_queue.sv =====
module jfrc_queue
    import jfrc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    input  event_t wr_data,
    output logic   wr_ready,
    output logic   rd_valid,
    output event_t rd_data,
    input  logic   rd_ready
);

    event_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

// ===== rtl/jfrc_tally.sv =====
module jfrc_tally
    import jfrc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      ev_valid,
    input  event_t    ev,
    output logic      ev_ready,
    output logic      m_valid,
    output out_item_t m_item,
    input  logic      m_ready
);

    logic [31:0] rep_reg, rej_reg, trn_reg;
    logic [31:0] rep_next, rej_next, trn_next;
    logic        valid_reg;
    out_item_t   item_reg;
    logic        take;

    assign ev_ready = !valid_reg || m_ready;
    assign take     = ev_valid && ev_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_comb begin
        rep_next = rep_reg; rej_next = rej_reg; trn_next = trn_reg;
        case (ev.verdict)
            V_REPLAYED:  rep_next = sat_add(rep_reg, 32'd1);
            V_TRUNCATED: trn_next = sat_add(trn_reg, ev.trunc_bytes);
            default:     rej_next = sat_add(rej_reg, 32'd1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.verdict <= ev.verdict;
            item_reg.record_sequence <= ev.record_sequence;
            item_reg.record_tick <= ev.record_tick;
            item_reg.record_epoch <= ev.record_epoch;
            item_reg.frame_start <= ev.frame_start;
            item_reg.kind_bytes <= ev.kind_bytes;
            item_reg.payload_bytes <= ev.payload_bytes;
            item_reg.replayed_total <= rep_next;
            item_reg.rejected_total <= rej_next;
            item_reg.truncated_total <= trn_next;
            item_reg.final_res <= ev.final_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg <= '0; rej_reg <= '0; trn_reg <= '0; valid_reg <= 1'b0;
        end else begin
            if (take) begin
                rep_reg <= rep_next; rej_reg <= rej_next; trn_reg <= trn_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/journal_frame_replay_checker.sv =====
// path: a verdict passes through the verdict queue and then the output register after the beat that closes its frame
// throughput: one stream byte per cycle; the parser stalls only when the
//   two-entry verdict queue and the output register are both full
// reset: synchronous active-low aresetn clears parser state, counters,
//   queue and the coordinator epoch
module journal_frame_replay_checker
    import jfrc_pkg::*;
#(
    parameter int unsigned MAX_RECORD_BYTES  = MAX_RECORD_BYTES_DEF,
    parameter int unsigned MAX_KIND_BYTES    = MAX_KIND_BYTES_DEF,
    parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [63:0] coord_epoch_reg;
    logic        ev_valid, q_ready, t_valid, t_ready;
    event_t      ev, t_ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) coord_epoch_reg <= '0;
        else if (cfg_we) coord_epoch_reg <= cfg_wdata;
    end

    assign s_ready = q_ready;

    jfrc_parser #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
        .MAX_KIND_BYTES(MAX_KIND_BYTES),
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_parser (
        .aclk, .aresetn, .coord_epoch(coord_epoch_reg),
        .byte_valid(s_valid && s_ready), .byte_in(s_data),
        .ev_valid, .ev
    );

    jfrc_queue u_queue (
        .aclk, .aresetn, .wr_valid(ev_valid), .wr_data(ev), .wr_ready(q_ready),
        .rd_valid(t_valid), .rd_data(t_ev), .rd_ready(t_ready)
    );

    jfrc_tally u_tally (
        .aclk, .aresetn, .ev_valid(t_valid), .ev(t_ev), .ev_ready(t_ready),
        .m_valid, .m_item(m_data), .m_ready
    );

endmodule

// ===== rtl/jfrc_checker.sv =====
module jfrc_checker
    import jfrc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.verdict <= V_TRUNCATED)
        else $error("verdict code out of range");

    a_term_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict >= V_MAGIC && m_data.verdict <= V_SEQUENCE
        |-> m_data.final_res)
        else $error("terminal stop without final flag");

    a_trunc_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == V_TRUNCATED |-> m_data.final_res)
        else $error("truncation not at end of stream");

endmodule

bind journal_frame_replay_checker jfrc_checker u_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);
